FILE: rtl/ksw_pkg.sv
package ksw_pkg;

   localparam int unsigned SCORE_W     = 32;
   localparam int unsigned NOVELTY_W   = 16;
   localparam int unsigned WSIZE_W     = 8;
   localparam int unsigned THRESH_W    = 16;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef logic [1:0] op_type;
   typedef logic [2:0] action_type;
   typedef logic [1:0] reason_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam op_type OP_FRAME = 2'd0;
   localparam op_type OP_DRAIN = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   localparam action_type ACT_NONE       = 3'd0;
   localparam action_type ACT_SAVE_NOW   = 3'd1;
   localparam action_type ACT_FLUSH_OPEN = 3'd2;
   localparam action_type ACT_OPEN       = 3'd3;
   localparam action_type ACT_CLOSE_SAVE = 3'd4;
   localparam action_type ACT_REPLACE    = 3'd5;
   localparam action_type ACT_KEEP       = 3'd6;

   localparam reason_type WHY_NONE  = 2'd0;
   localparam reason_type WHY_DRIFT = 2'd1;
   localparam reason_type WHY_FULL  = 2'd2;

   localparam csr_index_type REG_WINDOW_SIZE     = 1'd0;
   localparam csr_index_type REG_DRIFT_THRESHOLD = 1'd1;

endpackage

FILE: rtl/keyframe_sharpness_window_core.sv
// channel  | direction | handshake               | payload
// req      | in        | req_valid / req_ready   | op, is_accept, frame_score, novelty_valid, novelty
// rsp      | out       | rsp_valid / rsp_ready   | action, replace_best, close_reason, was_open
// csr      | in        | csr_write_enable        | csr_index, csr_data
//
// One item per cycle while the result register is free: each item is decided in the cycle
// it is accepted and its result appears in the result register on the next cycle; the state
// update and the result register share that single pass.
// req_ready is high while the result register is empty or its item is taken that cycle.
// Synchronous active-high reset clears window state, registers to their reset values
// and the result register.
module keyframe_sharpness_window_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic                          req_is_accept,
   input  logic [31:0]                   req_frame_score,
   input  logic                          req_novelty_valid,
   input  logic [15:0]                   req_novelty,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_action,
   output logic                          rsp_replace_best,
   output logic [1:0]                    rsp_close_reason,
   output logic                          rsp_was_open,
   input  logic                          csr_write_enable,
   input  ksw_pkg::csr_index_type        csr_index,
   input  logic [ksw_pkg::CSR_DATA_W-1:0] csr_data
);
   import ksw_pkg::*;

   logic                 window_size_gt1_ff;
   logic [WSIZE_W-1:0]   window_size_ff;
   logic [THRESH_W-1:0]  drift_threshold_ff;

   logic                 window_open_ff, window_open_in;
   logic [WSIZE_W-1:0]   frames_left_ff, frames_left_in;
   logic [SCORE_W-1:0]   best_score_ff, best_score_in;

   logic                 rsp_valid_ff;
   action_type           action_ff, action_in;
   logic                 replace_best_ff, replace_best_in;
   reason_type           close_reason_ff, close_reason_in;
   logic                 was_open_ff, was_open_in;

   logic                 accept_item;
   logic                 size_write;
   logic                 drift;
   logic                 better;
   logic [WSIZE_W-1:0]   frames_dec;
   logic [WSIZE_W-1:0]   wsize_written;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept_item = req_valid && req_ready;
   assign size_write  = csr_write_enable && (csr_index == REG_WINDOW_SIZE);

   assign drift = (drift_threshold_ff != '0) && req_novelty_valid &&
                  ({req_novelty, 1'b0} > {1'b0, drift_threshold_ff});
   assign better     = req_frame_score > best_score_ff;
   assign frames_dec = frames_left_ff - WSIZE_W'(1);
   assign wsize_written = (csr_data[WSIZE_W-1:0] == '0) ? WSIZE_W'(1)
                                                          : csr_data[WSIZE_W-1:0];

   always_comb begin
      window_open_in  = window_open_ff;
      frames_left_in  = frames_left_ff;
      best_score_in   = best_score_ff;
      action_in       = ACT_NONE;
      replace_best_in = 1'b0;
      close_reason_in = WHY_NONE;
      was_open_in     = 1'b0;
      unique case (req_op)
         OP_DRAIN: begin
            was_open_in    = window_open_ff;
            window_open_in = 1'b0;
            frames_left_in = '0;
         end
         OP_CLEAR: begin
            window_open_in = 1'b0;
            frames_left_in = '0;
            best_score_in  = '0;
         end
         OP_FRAME: begin
            priority if (req_is_accept) begin
               if (!window_size_gt1_ff) begin
                  window_open_in = 1'b0;
                  frames_left_in = '0;
                  action_in      = ACT_SAVE_NOW;
               end else begin
                  best_score_in   = req_frame_score;
                  frames_left_in  = window_size_ff - WSIZE_W'(1);
                  window_open_in  = 1'b1;
                  replace_best_in = 1'b1;
                  action_in       = window_open_ff ? ACT_FLUSH_OPEN : ACT_OPEN;
               end
            end else if (!window_open_ff || frames_left_ff == '0) begin
               action_in = ACT_NONE;
            end else if (drift) begin
               window_open_in  = 1'b0;
               frames_left_in  = '0;
               action_in       = ACT_CLOSE_SAVE;
               close_reason_in = WHY_DRIFT;
            end else begin
               if (better) begin
                  best_score_in = req_frame_score;
               end
               replace_best_in = better;
               frames_left_in  = frames_dec;
               if (frames_dec == '0) begin
                  window_open_in  = 1'b0;
                  action_in       = ACT_CLOSE_SAVE;
                  close_reason_in = WHY_FULL;
               end else begin
                  action_in = better ? ACT_REPLACE : ACT_KEEP;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff     <= WSIZE_W'(1);
         window_size_gt1_ff <= 1'b0;
         drift_threshold_ff <= '0;
         window_open_ff     <= 1'b0;
         frames_left_ff     <= '0;
         best_score_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept_item) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept_item && !size_write) begin
            window_open_ff <= window_open_in;
            frames_left_ff <= frames_left_in;
            best_score_ff  <= best_score_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_WINDOW_SIZE: begin
                  window_size_ff     <= wsize_written;
                  window_size_gt1_ff <= wsize_written > WSIZE_W'(1);
                  window_open_ff     <= 1'b0;
                  frames_left_ff     <= '0;
                  best_score_ff      <= '0;
               end
               REG_DRIFT_THRESHOLD: begin
                  drift_threshold_ff <= csr_data[THRESH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_item) begin
         action_ff       <= action_in;
         replace_best_ff <= replace_best_in;
         close_reason_ff <= close_reason_in;
         was_open_ff     <= was_open_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_replace_best = replace_best_ff;
   assign rsp_close_reason = close_reason_ff;
   assign rsp_was_open     = was_open_ff;

endmodule

FILE: rtl/ksw_checker.sv
module ksw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_action,
   input logic       rsp_replace_best,
   input logic [1:0] rsp_close_reason,
   input logic       rsp_was_open
);
   import ksw_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_replace_best) && $stable(rsp_close_reason) && $stable(rsp_was_open))
      else $error("rsp item changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty result register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_drain_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_open |-> rsp_action == ACT_NONE && !rsp_replace_best &&
      rsp_close_reason == WHY_NONE)
      else $error("drain item carries frame fields");

   a_close_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_close_reason != WHY_NONE |-> rsp_action == ACT_CLOSE_SAVE &&
      !rsp_was_open && !(rsp_close_reason == WHY_DRIFT && rsp_replace_best))
      else $error("close reason without close action");

endmodule

bind keyframe_sharpness_window_core ksw_checker u_ksw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_action       (rsp_action),
   .rsp_replace_best (rsp_replace_best),
   .rsp_close_reason (rsp_close_reason),
   .rsp_was_open     (rsp_was_open)
);
